>>> design/mxt_pkg.sv
package mxt_pkg;

    localparam int NODE_COUNT = 32768;
    localparam int DATA_BITS  = 32;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int USED_W     = NODE_W + 1;
    localparam int LEVEL_W    = $clog2(DATA_BITS);
    localparam int LINK_W     = 2 * NODE_W;

    localparam logic [DATA_BITS-1:0] INT_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    typedef struct packed {
        logic [NODE_W-1:0] link1;
        logic [NODE_W-1:0] link0;
    } links_t;

    typedef struct packed {
        links_t links;
        logic   key_bit;
        logic   query;
        logic   top;
    } level_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] child;
        logic              dir;
        logic              found;
    } level_out_t;

endpackage

>>> design/mxt_ram.sv
module mxt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mxt_level.sv
// one trie level: picks the child to follow for a query or an insert
module mxt_level (
    input  mxt_pkg::level_in_t  lvl_in,
    output mxt_pkg::level_out_t lvl_out
);

    logic                      want;
    logic [mxt_pkg::NODE_W-1:0] c_want;
    logic [mxt_pkg::NODE_W-1:0] c_alt;

    always_comb begin
        if (lvl_in.query) begin
            want = lvl_in.top ? lvl_in.key_bit : ~lvl_in.key_bit;
        end else begin
            want = lvl_in.key_bit;
        end
        c_want = want ? lvl_in.links.link1 : lvl_in.links.link0;
        c_alt  = want ? lvl_in.links.link0 : lvl_in.links.link1;

        if (c_want != '0) begin
            lvl_out.child = c_want;
            lvl_out.dir   = want;
            lvl_out.found = 1'b1;
        end else if (lvl_in.query && (c_alt != '0)) begin
            lvl_out.child = c_alt;
            lvl_out.dir   = ~want;
            lvl_out.found = 1'b1;
        end else begin
            lvl_out.child = '0;
            lvl_out.dir   = want;
            lvl_out.found = 1'b0;
        end
    end

endmodule

>>> design/max_subarray_xor_trie.sv
// channel  dir  tdata                          tuser     tlast
// s_       in   [31:0] value                   [0] first [0] last
// m_       out  [31:0] max_xor, [32] overflow  -         -
//
// Each trie level is a node RAM read state, then a decide/write state; a query
// and an insert walk 32 levels each, and an element with first set also does a
// seed insert of zero before its query. A dead end ends the query early.
// Reset clears control state; root links live in flip-flops, no clearing pass.
// s_tready is high only between elements; a pending result stalls the next last.
module max_subarray_xor_trie (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] first
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] max_xor, [32] overflow
);

    localparam int NW = mxt_pkg::NODE_W;
    localparam int DW = mxt_pkg::DATA_BITS;
    localparam int LW = mxt_pkg::LEVEL_W;
    localparam int UW = mxt_pkg::USED_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_QRD, ST_QDO, ST_IRD, ST_IDO, ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [DW-1:0]        prefix_reg, prefix_next;
    logic [DW-1:0]        best_reg, best_next;
    logic [DW-1:0]        key_reg, key_next;
    logic [DW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        val_reg, val_next;
    logic                 last_reg, last_next;
    logic                 seed_reg, seed_next;
    logic                 fresh_reg, fresh_next;
    logic                 full_reg, full_next;
    logic [UW-1:0]        used_reg, used_next;
    logic [NW-1:0]        node_reg, node_next;
    logic [LW-1:0]        level_reg, level_next;
    mxt_pkg::links_t      root_reg, root_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_tdata_reg, m_tdata_next;

    logic                 rd_en;
    logic [mxt_pkg::LINK_W-1:0] rd_data;
    logic                 wr_en;
    mxt_pkg::links_t      wr_links;
    mxt_pkg::links_t      cur_links;
    mxt_pkg::level_in_t   lvl_in;
    mxt_pkg::level_out_t  lvl_out;
    logic                 key_bit;
    logic                 at_top;
    logic                 at_bottom;

    assign key_bit   = key_reg[level_reg];
    assign at_top    = (level_reg == LW'(DW - 1));
    assign at_bottom = (level_reg == '0);

    always_comb begin
        if (fresh_reg) begin
            cur_links = '0;
        end else if (node_reg == '0) begin
            cur_links = root_reg;
        end else begin
            cur_links = mxt_pkg::links_t'(rd_data);
        end
        lvl_in.links   = cur_links;
        lvl_in.key_bit = key_bit;
        lvl_in.query   = (state_reg == ST_QDO);
        lvl_in.top     = at_top;
    end

    mxt_level u_level (
        .lvl_in  (lvl_in),
        .lvl_out (lvl_out)
    );

    mxt_ram #(
        .WIDTH (mxt_pkg::LINK_W),
        .DEPTH (mxt_pkg::NODE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (node_reg),
        .wr_data (wr_links),
        .rd_en   (rd_en),
        .rd_addr (node_reg),
        .rd_data (rd_data)
    );

    assign rd_en    = (state_reg == ST_QRD) || (state_reg == ST_IRD);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        prefix_next   = prefix_reg;
        best_next     = best_reg;
        key_next      = key_reg;
        acc_next      = acc_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        seed_next     = seed_reg;
        fresh_next    = fresh_reg;
        full_next     = full_reg;
        used_next     = used_reg;
        node_next     = node_reg;
        level_next    = level_reg;
        root_next     = root_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_links      = cur_links;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next   = s_tdata;
                    last_next  = s_tlast;
                    node_next  = '0;
                    level_next = LW'(DW - 1);
                    fresh_next = 1'b0;
                    acc_next   = '0;
                    if (s_tuser[0]) begin
                        root_next   = '0;
                        used_next   = UW'(1);
                        full_next   = 1'b0;
                        prefix_next = '0;
                        best_next   = mxt_pkg::INT_MIN;
                        key_next    = '0;
                        seed_next   = 1'b1;
                        state_next  = ST_IRD;
                    end else begin
                        prefix_next = prefix_reg ^ s_tdata;
                        key_next    = prefix_reg ^ s_tdata;
                        seed_next   = 1'b0;
                        state_next  = ST_QRD;
                    end
                end
            end
            ST_QRD: begin
                state_next = ST_QDO;
            end
            ST_QDO: begin
                acc_next[level_reg] = key_bit ^ lvl_out.dir;
                if (!lvl_out.found) begin
                    node_next  = '0;
                    level_next = LW'(DW - 1);
                    state_next = ST_IRD;
                end else if (at_bottom) begin
                    if ($signed(acc_next) > $signed(best_reg)) begin
                        best_next = acc_next;
                    end
                    node_next  = '0;
                    level_next = LW'(DW - 1);
                    state_next = ST_IRD;
                end else begin
                    node_next  = lvl_out.child;
                    level_next = level_reg - LW'(1);
                    state_next = ST_QRD;
                end
            end
            ST_IRD: begin
                state_next = ST_IDO;
            end
            ST_IDO: begin
                state_next = ST_IRD;
                if (lvl_out.found) begin
                    node_next  = lvl_out.child;
                    level_next = level_reg - LW'(1);
                end else if (used_reg >= UW'(mxt_pkg::NODE_COUNT)) begin
                    full_next = 1'b1;
                    wr_links  = '0;
                    wr_en     = fresh_reg;
                end else begin
                    if (key_bit) begin
                        wr_links.link1 = used_reg[NW-1:0];
                    end else begin
                        wr_links.link0 = used_reg[NW-1:0];
                    end
                    if (node_reg == '0) begin
                        root_next = wr_links;
                    end else begin
                        wr_en = 1'b1;
                    end
                    node_next  = used_reg[NW-1:0];
                    used_next  = used_reg + UW'(1);
                    fresh_next = 1'b1;
                    level_next = level_reg - LW'(1);
                end

                if (at_bottom || (!lvl_out.found
                        && (used_reg >= UW'(mxt_pkg::NODE_COUNT)))) begin
                    node_next  = '0;
                    level_next = LW'(DW - 1);
                    fresh_next = 1'b0;
                    acc_next   = '0;
                    if (seed_reg) begin
                        seed_next   = 1'b0;
                        prefix_next = prefix_reg ^ val_reg;
                        key_next    = prefix_reg ^ val_reg;
                        state_next  = ST_QRD;
                    end else if (last_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, full_reg, best_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prefix_reg   <= '0;
            best_reg     <= mxt_pkg::INT_MIN;
            seed_reg     <= 1'b0;
            fresh_reg    <= 1'b0;
            full_reg     <= 1'b0;
            used_reg     <= UW'(1);
            root_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prefix_reg   <= prefix_next;
            best_reg     <= best_next;
            seed_reg     <= seed_next;
            fresh_reg    <= fresh_next;
            full_reg     <= full_next;
            used_reg     <= used_next;
            root_reg     <= root_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg     <= key_next;
        acc_reg     <= acc_next;
        val_reg     <= val_next;
        last_reg    <= last_next;
        node_reg    <= node_next;
        level_reg   <= level_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg <= UW'(mxt_pkg::NODE_COUNT)) && (used_reg != '0))
        else $error("node count out of range");

    a_node_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QDO || state_reg == ST_IDO) |-> (UW'(node_reg) < used_reg))
        else $error("walk on unallocated node");

    a_full_used: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (used_reg == UW'(mxt_pkg::NODE_COUNT)))
        else $error("full flag without full store");

    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result outside output step");

    a_write_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_IDO && node_reg != '0))
        else $error("stray node write");
`endif

endmodule

>>> tb/sv/max_subarray_xor_trie_tb.sv
`timescale 1ns / 100ps

module max_subarray_xor_trie_tb;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [31:0] max_xor;
        logic        overflow;
    } xor_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    max_subarray_xor_trie dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // trie shadow
    logic [mxt_pkg::NODE_W-1:0] trie_link0 [mxt_pkg::NODE_COUNT];
    logic [mxt_pkg::NODE_W-1:0] trie_link1 [mxt_pkg::NODE_COUNT];
    int unsigned       trie_nodes;
    bit                trie_full;
    logic [31:0]       run_prefix;
    logic [31:0]       run_best;

    xor_result_t expected_max_q[$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int error_count = 0;
    int element_count = 0;
    int result_count = 0;
    int overflow_seen = 0;
    int dead_end_count = 0;

    function automatic void trie_clear();
        trie_link0[0] = '0;
        trie_link1[0] = '0;
        trie_nodes = 1;
        trie_full = 1'b0;
    endfunction

    function automatic void trie_insert(logic [31:0] key);
        int unsigned node;
        int unsigned next;
        logic        b;
        node = 0;
        for (int lvl = mxt_pkg::DATA_BITS - 1; lvl >= 0; lvl--) begin
            b = key[lvl];
            next = 32'(b ? trie_link1[node] : trie_link0[node]);
            if (next == 0) begin
                if (trie_nodes >= mxt_pkg::NODE_COUNT) begin
                    trie_full = 1'b1;
                    return;
                end
                next = trie_nodes;
                trie_nodes++;
                trie_link0[next] = '0;
                trie_link1[next] = '0;
                if (b) trie_link1[node] = mxt_pkg::NODE_W'(next);
                else trie_link0[node] = mxt_pkg::NODE_W'(next);
            end
            node = next;
        end
    endfunction

    function automatic bit trie_best_match(logic [31:0] key, output logic [31:0] best_xor);
        int unsigned node;
        int unsigned next;
        logic        b;
        logic        want;
        node = 0;
        best_xor = '0;
        for (int lvl = mxt_pkg::DATA_BITS - 1; lvl >= 0; lvl--) begin
            b = key[lvl];
            want = (lvl == mxt_pkg::DATA_BITS - 1) ? b : ~b;
            next = 32'(want ? trie_link1[node] : trie_link0[node]);
            if (next == 0) begin
                want = ~want;
                next = 32'(want ? trie_link1[node] : trie_link0[node]);
                if (next == 0) return 1'b0;
            end
            best_xor[lvl] = b ^ want;
            node = next;
        end
        return 1'b1;
    endfunction

    function automatic void predict_element(logic [31:0] v, bit f, bit l);
        logic [31:0] cand;
        xor_result_t r;
        if (f) begin
            trie_clear();
            run_prefix = '0;
            run_best = mxt_pkg::INT_MIN;
            trie_insert('0);
        end
        run_prefix ^= v;
        if (trie_best_match(run_prefix, cand)) begin
            if ($signed(cand) > $signed(run_best)) run_best = cand;
        end else begin
            dead_end_count++;
        end
        trie_insert(run_prefix);
        if (l) begin
            r.max_xor = run_best;
            r.overflow = trie_full;
            if (trie_full) overflow_seen++;
            expected_max_q.push_back(r);
        end
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] corners [4];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        case ($urandom_range(0, 5))
            0, 1: begin
                return $urandom;
            end
            2: begin
                return $urandom_range(0, 15);
            end
            3: begin
                return 32'h1 << $urandom_range(0, 31);
            end
            4: begin
                return corners[$urandom_range(0, 3)];
            end
            default: begin
                return $urandom | 32'h8000_0000;
            end
        endcase
    endfunction

    // call at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_element(input logic [31:0] v, input bit f, input bit l);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tuser <= f;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_element(v, f, l);
        element_count++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_max_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result stall bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        xor_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_max_q.size() == 0) begin
                $display("%0t: unexpected result max_xor=%h overflow=%b",
                         $realtime, m_tdata[31:0], m_tdata[32]);
                error_count++;
            end else begin
                exp_r = expected_max_q.pop_front();
                if (m_tdata[31:0] !== exp_r.max_xor) begin
                    $display("%0t: max_xor mismatch expected %h actual %h",
                             $realtime, exp_r.max_xor, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[32] !== exp_r.overflow) begin
                    $display("%0t: overflow mismatch expected %b actual %b",
                             $realtime, exp_r.overflow, m_tdata[32]);
                    error_count++;
                end
            end
        end
    end

    // elements before any first mark; the first one queries an empty trie
    task automatic test_no_first_after_reset();
        send_element(32'h0000_0005, 1'b0, 1'b1);
        send_element(32'h0000_0003, 1'b0, 1'b1);
    endtask

    task automatic test_directed_corners();
        send_element(32'h8000_0000, 1'b1, 1'b1);
        send_element(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_element(32'h0000_0000, 1'b1, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_element(32'h8000_0000, 1'b1, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0, 1'b1);
        send_element(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_element(32'h8000_0000, 1'b0, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_element(32'h0000_0001, 1'b0, 1'b1);
        // continue the previous array after its last
        send_element(32'h1234_5678, 1'b0, 1'b1);
        // abandoned array, then restart
        send_element(32'h0000_0003, 1'b1, 1'b0);
        send_element(32'h0000_0009, 1'b0, 1'b0);
        send_element(32'h0000_000A, 1'b1, 1'b1);
        send_element(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_store_full();
        send_element($urandom, 1'b1, 1'b0);
        for (int i = 0; i < 1698; i++) send_element($urandom, 1'b0, 1'b0);
        send_element($urandom, 1'b0, 1'b1);
        for (int i = 0; i < 4; i++) send_element($urandom, 1'b0, 1'b0);
        send_element(pick_value(), 1'b0, 1'b1);
        // first clears the full state
        send_element(pick_value(), 1'b1, 1'b1);
    endtask

    task automatic random_arrays(input int n_items);
        int sent;
        int len;
        bit start;
        bit close;
        bit l;
        sent = 0;
        while (sent < n_items) begin
            start = ($urandom_range(0, 9) != 0);
            close = ($urandom_range(0, 9) != 0);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                l = (close && i == len - 1) || ($urandom_range(0, 29) == 0);
                send_element(pick_value(), start && i == 0, l);
            end
            sent += len;
        end
        send_element(pick_value(), 1'b0, 1'b1);
    endtask

    task automatic test_random_arrays();
        random_arrays(120);
        wait_for_results();
        random_arrays(80);
    endtask

    task automatic test_random_no_idle();
        idle_on = 1'b0;
        random_arrays(60);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_prefix = '0;
        run_best = mxt_pkg::INT_MIN;
        trie_clear();

        test_no_first_after_reset();
        test_directed_corners();
        wait_for_results();
        test_store_full();
        test_random_arrays();
        test_random_no_idle();
        wait_for_results();

        $display("Sent %0d elements, checked %0d results;", element_count, result_count);
        $display("%0d with store overflow, %0d dead-end queries.",
                 overflow_seen, dead_end_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", expected_max_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
